// File: sv/alpha_beta_tracker_2d_unit_defines.svh
// Assertion helpers used by the tracker controller.
`ifndef ALPHA_BETA_TRACKER_2D_UNIT_DEFINES_SVH
`define ALPHA_BETA_TRACKER_2D_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ABT2D_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define ABT2D_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: sv/abt2d_pkg.sv
`default_nettype none

package abt2d_pkg;

	// Configuration register indexes
	localparam int CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] CFG_THETA     = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_MIN_VEL_DT = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_GATE_DIST  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_GATE_TIME  = 3'd3;

	// Arithmetic unit widths
	localparam int MUL_W  = 48;
	localparam int PROD_W = 2 * MUL_W;
	localparam int DVD_W  = 48;
	localparam int DVS_W  = 32;
	localparam int RAD_W  = 64;
	localparam int ROOT_W = RAD_W / 2;

	typedef struct packed {
		logic              req_type;
		logic [31:0]       stamp;
		logic signed [31:0] pos_x;
		logic signed [31:0] pos_y;
	} meas_item_t;

	typedef struct packed {
		logic signed [31:0] filt_x;
		logic signed [31:0] filt_y;
		logic [31:0]       gap;
		logic              matched;
	} res_item_t;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_DECODE,
		ST_SEED,
		ST_GV,
		ST_GP,
		ST_PX,
		ST_PY,
		ST_RES,
		ST_VX,
		ST_DVX,
		ST_VY,
		ST_DVY,
		ST_GX,
		ST_GY,
		ST_SQX,
		ST_SQY,
		ST_ROOT,
		ST_DONE
	} ctl_state_t;

	typedef enum logic [4:0] {
		OP_NONE,
		OP_SEED,
		OP_GV,
		OP_GP,
		OP_PX,
		OP_PY,
		OP_RES,
		OP_VX,
		OP_DVX,
		OP_VY,
		OP_DVY,
		OP_GX,
		OP_GY,
		OP_SQX,
		OP_SQY,
		OP_ROOT,
		OP_EMIT
	} dp_op_t;

	typedef struct packed {
		dp_op_t op;
		logic   accept;
		logic   start;
	} cmd_t;

	typedef struct packed {
		logic mul_done;
		logic div_done;
		logic root_done;
		logic is_query;
		logic started;
		logic gate_ok;
		logic vel_upd;
		logic sum_ok;
		logic out_free;
	} sts_t;

endpackage

`default_nettype wire

// File: sv/abt2d_mul.sv
`default_nettype none

module abt2d_mul (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [abt2d_pkg::MUL_W-1:0]   a,
	input  logic [abt2d_pkg::MUL_W-1:0]   b,
	output logic                          done,
	output logic [abt2d_pkg::PROD_W-1:0]  prod
);
	import abt2d_pkg::*;

	localparam int DIG_W = 16;
	localparam int NDIG  = MUL_W / DIG_W;
	localparam int CNT_W = $clog2(NDIG);

	logic                   busy_q;
	logic                   done_q;
	logic [CNT_W-1:0]       cnt_q;
	logic [MUL_W-1:0]       a_q;
	logic [MUL_W-1:0]       b_q;
	logic [PROD_W-1:0]      acc_q;
	logic [MUL_W+DIG_W-1:0] pp;

	// one digit of b per cycle, most significant first
	assign pp = a_q * b_q[MUL_W-1 -: DIG_W];

	// advance control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(NDIG - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// shift and accumulate partial products
	always_ff @(posedge clk) begin
		if (start) begin
			a_q   <= a;
			b_q   <= b;
			acc_q <= '0;
		end else if (busy_q) begin
			acc_q <= (acc_q << DIG_W) + PROD_W'(pp);
			b_q   <= b_q << DIG_W;
		end
	end

	assign done = done_q;
	assign prod = acc_q;

endmodule

`default_nettype wire

// File: sv/abt2d_div.sv
`default_nettype none

module abt2d_div (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [abt2d_pkg::DVD_W-1:0]  dividend,
	input  logic [abt2d_pkg::DVS_W-1:0]  divisor,
	output logic                         done,
	output logic [abt2d_pkg::DVD_W-1:0]  quot
);
	import abt2d_pkg::*;

	localparam int CNT_W = $clog2(DVD_W);

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [DVS_W-1:0] rem_q;
	logic [DVS_W-1:0] dvs_q;
	logic [DVD_W-1:0] q_q;
	logic [DVS_W:0]   trial;
	logic             fit;

	// restoring step: one quotient bit per cycle
	assign trial = {rem_q, q_q[DVD_W-1]};
	assign fit   = trial >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(DVD_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// shift dividend out and quotient in
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			dvs_q <= divisor;
			q_q   <= dividend;
		end else if (busy_q) begin
			rem_q <= fit ? DVS_W'(trial - {1'b0, dvs_q}) : DVS_W'(trial);
			q_q   <= {q_q[DVD_W-2:0], fit};
		end
	end

	assign done = done_q;
	assign quot = q_q;

endmodule

`default_nettype wire

// File: sv/abt2d_sqrt.sv
`default_nettype none

module abt2d_sqrt (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [abt2d_pkg::RAD_W-1:0]   rad,
	output logic                          done,
	output logic [abt2d_pkg::ROOT_W-1:0]  root
);
	import abt2d_pkg::*;

	localparam int REM_W = ROOT_W + 2;
	localparam int CNT_W = $clog2(ROOT_W);

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [REM_W-1:0] rem_q;
	logic [ROOT_W-1:0] root_q;
	logic [RAD_W-1:0] rad_q;
	logic [REM_W+1:0] rem_sh;
	logic [REM_W+1:0] trial;
	logic             fit;

	// one root bit per cycle from two radicand bits
	assign rem_sh = {rem_q, rad_q[RAD_W-1 -: 2]};
	assign trial  = {2'b00, root_q, 2'b01};
	assign fit    = rem_sh >= trial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(ROOT_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q  <= '0;
			root_q <= '0;
			rad_q  <= rad;
		end else if (busy_q) begin
			rem_q  <= fit ? REM_W'(rem_sh - trial) : REM_W'(rem_sh);
			root_q <= {root_q[ROOT_W-2:0], fit};
			rad_q  <= rad_q << 2;
		end
	end

	assign done = done_q;
	assign root = root_q;

endmodule

`default_nettype wire

// File: sv/abt2d_ctrl.sv
`default_nettype none
`include "alpha_beta_tracker_2d_unit_defines.svh"

module abt2d_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             meas_valid,
	output logic             meas_stall,
	output abt2d_pkg::cmd_t  cmd,
	input  abt2d_pkg::sts_t  sts
);
	import abt2d_pkg::*;

	ctl_state_t state_q;
	ctl_state_t state_d;
	logic       issued_q;
	logic       unit_st;

	// states that run one of the iterative units
	assign unit_st = state_q inside {ST_GV, ST_GP, ST_PX, ST_PY, ST_VX, ST_DVX, ST_VY,
		ST_DVY, ST_GX, ST_GY, ST_SQX, ST_SQY, ST_ROOT};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			issued_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			issued_q <= (state_d == state_q) && (issued_q || cmd.start);
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:   if (meas_valid) state_d = ST_DECODE;
			ST_DECODE: begin
				if (!sts.started) state_d = sts.is_query ? ST_DONE : ST_SEED;
				else if (!sts.is_query) state_d = ST_GV;
				else state_d = sts.gate_ok ? ST_PX : ST_DONE;
			end
			ST_SEED:   state_d = ST_DONE;
			ST_GV:     if (sts.mul_done) state_d = ST_GP;
			ST_GP:     if (sts.mul_done) state_d = ST_PX;
			ST_PX:     if (sts.mul_done) state_d = ST_PY;
			ST_PY:     if (sts.mul_done) state_d = ST_RES;
			ST_RES: begin
				if (sts.is_query) state_d = ST_SQX;
				else state_d = sts.vel_upd ? ST_VX : ST_GX;
			end
			ST_VX:     if (sts.mul_done) state_d = ST_DVX;
			ST_DVX:    if (sts.div_done) state_d = ST_VY;
			ST_VY:     if (sts.mul_done) state_d = ST_DVY;
			ST_DVY:    if (sts.div_done) state_d = ST_GX;
			ST_GX:     if (sts.mul_done) state_d = ST_GY;
			ST_GY:     if (sts.mul_done) state_d = ST_DONE;
			ST_SQX:    if (sts.mul_done) state_d = ST_SQY;
			ST_SQY:    if (sts.mul_done) state_d = ST_ROOT;
			ST_ROOT:   if (!sts.sum_ok || sts.root_done) state_d = ST_DONE;
			ST_DONE:   if (sts.out_free) state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	// command to the datapath
	always_comb begin
		cmd        = '0;
		cmd.accept = (state_q == ST_IDLE) && meas_valid;
		cmd.start  = unit_st && !issued_q && !(state_q == ST_ROOT && !sts.sum_ok);
		meas_stall = state_q != ST_IDLE;
		unique case (state_q)
			ST_IDLE:   cmd.op = OP_NONE;
			ST_DECODE: cmd.op = OP_NONE;
			ST_SEED:   cmd.op = OP_SEED;
			ST_GV:     cmd.op = OP_GV;
			ST_GP:     cmd.op = OP_GP;
			ST_PX:     cmd.op = OP_PX;
			ST_PY:     cmd.op = OP_PY;
			ST_RES:    cmd.op = OP_RES;
			ST_VX:     cmd.op = OP_VX;
			ST_DVX:    cmd.op = OP_DVX;
			ST_VY:     cmd.op = OP_VY;
			ST_DVY:    cmd.op = OP_DVY;
			ST_GX:     cmd.op = OP_GX;
			ST_GY:     cmd.op = OP_GY;
			ST_SQX:    cmd.op = OP_SQX;
			ST_SQY:    cmd.op = OP_SQY;
			ST_ROOT:   cmd.op = OP_ROOT;
			ST_DONE:   cmd.op = OP_EMIT;
			default:   cmd.op = OP_NONE;
		endcase
	end

	`ABT2D_ASSERT_NXT(a_start_pulse, clk, arst_n, cmd.start, !cmd.start, "unit start held over two cycles")
	`ABT2D_ASSERT_IMP(a_mul_done_st, clk, arst_n, sts.mul_done, unit_st && state_q != ST_DVX && state_q != ST_DVY && state_q != ST_ROOT, "multiplier done outside a multiply step")
	`ABT2D_ASSERT_IMP(a_div_done_st, clk, arst_n, sts.div_done, state_q == ST_DVX || state_q == ST_DVY, "divider done outside a divide step")
	`ABT2D_ASSERT_IMP(a_root_done_st, clk, arst_n, sts.root_done, state_q == ST_ROOT, "square root done outside its step")

endmodule

`default_nettype wire

// File: sv/abt2d_dp.sv
`default_nettype none

module abt2d_dp (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  abt2d_pkg::cmd_t                      cmd,
	output abt2d_pkg::sts_t                      sts,
	input  abt2d_pkg::meas_item_t                meas_data,
	output logic                                 res_valid,
	input  logic                                 res_stall,
	output abt2d_pkg::res_item_t                 res_data,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [abt2d_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [31:0]                          cfg_data
);
	import abt2d_pkg::*;

	// saturate to the signed 32-bit range
	function automatic logic signed [31:0] sat32_f(input logic signed [35:0] v);
		if (v > 36'sd2147483647) return 32'sh7FFFFFFF;
		if (v < -36'sd2147483648) return 32'sh80000000;
		return v[31:0];
	endfunction

	// saturate to the signed 48-bit range
	function automatic logic signed [47:0] sat48_f(input logic signed [49:0] v);
		if (v > 50'sd140737488355327) return 48'sh7FFFFFFFFFFF;
		if (v < -50'sd140737488355328) return 48'sh800000000000;
		return v[47:0];
	endfunction

	// base plus or minus a magnitude
	function automatic logic signed [35:0] addmag36(input logic signed [31:0] base,
		input logic [33:0] mag, input logic neg);
		logic signed [35:0] b;
		logic signed [35:0] m;
		b = 36'(base);
		m = signed'({2'b00, mag});
		return neg ? b - m : b + m;
	endfunction

	// prediction: last point moved by a signed offset magnitude
	function automatic logic signed [31:0] pred_f(input logic signed [31:0] base,
		input logic [63:0] mag, input logic neg);
		if (|mag[63:34]) return neg ? 32'sh80000000 : 32'sh7FFFFFFF;
		return sat32_f(addmag36(base, mag[33:0], neg));
	endfunction

	function automatic logic [47:0] abs48(input logic signed [47:0] v);
		return v[47] ? 48'(-v) : 48'(v);
	endfunction

	function automatic logic [32:0] abs33(input logic signed [32:0] v);
		return v[32] ? 33'(-v) : 33'(v);
	endfunction

	// configuration
	logic [16:0] theta_q;
	logic [31:0] min_dt_q;
	logic [31:0] gate_dist_q;
	logic [31:0] gate_time_q;

	// track state
	logic               started_q;
	logic signed [31:0] last_x_q;
	logic signed [31:0] last_y_q;
	logic [31:0]        last_stamp_q;
	logic signed [47:0] vel_x_q;
	logic signed [47:0] vel_y_q;

	// item in work
	logic               req_q;
	logic [31:0]        stamp_q;
	logic signed [31:0] px_q;
	logic signed [31:0] py_q;
	logic signed [32:0] dt_q;
	logic [32:0]        gv_q;
	logic [32:0]        gp_q;
	logic signed [31:0] pred_x_q;
	logic signed [31:0] pred_y_q;
	logic signed [32:0] r_x_q;
	logic signed [32:0] r_y_q;
	logic [47:0]        vm_q;
	logic               vneg_q;
	logic [64:0]        sq_x_q;
	logic [65:0]        sum_q;
	logic [31:0]        gap_q;
	logic               matched_q;

	// result register
	logic      res_valid_q;
	res_item_t res_q;

	// unit hookup
	logic [16:0]       t_c;
	logic [16:0]       omt;
	logic              mul_start;
	logic [MUL_W-1:0]  mul_a;
	logic [MUL_W-1:0]  mul_b;
	logic              mul_done;
	logic [PROD_W-1:0] prod;
	logic              div_start;
	logic [DVD_W-1:0]  div_n;
	logic              div_done;
	logic [DVD_W-1:0]  quot;
	logic              root_start;
	logic              root_done;
	logic [ROOT_W-1:0] root;
	logic              out_free;

	assign t_c = (theta_q > 17'd65536) ? 17'd65536 : theta_q;
	assign omt = 17'd65536 - t_c;

	// route operands by step
	always_comb begin
		mul_a      = '0;
		mul_b      = '0;
		mul_start  = 1'b0;
		div_start  = 1'b0;
		root_start = 1'b0;
		div_n      = vm_q;
		case (cmd.op)
			OP_GV: begin
				mul_a = MUL_W'(omt);
				mul_b = MUL_W'(omt);
				mul_start = cmd.start;
			end
			OP_GP: begin
				mul_a = MUL_W'(t_c);
				mul_b = MUL_W'(t_c);
				mul_start = cmd.start;
			end
			OP_PX: begin
				mul_a = abs48(vel_x_q);
				mul_b = MUL_W'(abs33(dt_q));
				mul_start = cmd.start;
			end
			OP_PY: begin
				mul_a = abs48(vel_y_q);
				mul_b = MUL_W'(abs33(dt_q));
				mul_start = cmd.start;
			end
			OP_VX: begin
				mul_a = MUL_W'(gv_q);
				mul_b = MUL_W'(abs33(r_x_q));
				mul_start = cmd.start;
			end
			OP_VY: begin
				mul_a = MUL_W'(gv_q);
				mul_b = MUL_W'(abs33(r_y_q));
				mul_start = cmd.start;
			end
			OP_GX: begin
				mul_a = MUL_W'(gp_q);
				mul_b = MUL_W'(abs33(r_x_q));
				mul_start = cmd.start;
			end
			OP_GY: begin
				mul_a = MUL_W'(gp_q);
				mul_b = MUL_W'(abs33(r_y_q));
				mul_start = cmd.start;
			end
			OP_SQX: begin
				mul_a = MUL_W'(abs33(r_x_q));
				mul_b = MUL_W'(abs33(r_x_q));
				mul_start = cmd.start;
			end
			OP_SQY: begin
				mul_a = MUL_W'(abs33(r_y_q));
				mul_b = MUL_W'(abs33(r_y_q));
				mul_start = cmd.start;
			end
			OP_DVX, OP_DVY: div_start = cmd.start;
			OP_ROOT: root_start = cmd.start;
			default: mul_start = 1'b0;
		endcase
	end

	abt2d_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start),
		.a      (mul_a),
		.b      (mul_b),
		.done   (mul_done),
		.prod   (prod)
	);

	abt2d_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_n),
		.divisor  (dt_q[31:0]),
		.done     (div_done),
		.quot     (quot)
	);

	abt2d_sqrt u_sqrt (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (root_start),
		.rad    (sum_q[RAD_W-1:0]),
		.done   (root_done),
		.root   (root)
	);

	assign out_free = !res_valid_q || !res_stall;

	// status back to the controller
	always_comb begin
		sts           = '0;
		sts.mul_done  = mul_done;
		sts.div_done  = div_done;
		sts.root_done = root_done;
		sts.is_query  = req_q;
		sts.started   = started_q;
		sts.gate_ok   = !dt_q[32] && !((gate_time_q != 32'd0) && (dt_q[31:0] > gate_time_q));
		sts.vel_upd   = !dt_q[32] && (dt_q[31:0] != 32'd0) && (dt_q[31:0] >= min_dt_q);
		sts.sum_ok    = sum_q[65:64] == 2'b00;
		sts.out_free  = out_free;
	end

	// configuration writes
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			theta_q     <= 17'd32768;
			min_dt_q    <= 32'd6554;
			gate_dist_q <= 32'd655360;
			gate_time_q <= 32'd0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_THETA:      theta_q     <= cfg_data[16:0];
				CFG_MIN_VEL_DT: min_dt_q    <= cfg_data;
				CFG_GATE_DIST:  gate_dist_q <= cfg_data;
				CFG_GATE_TIME:  gate_time_q <= cfg_data;
				default:        theta_q     <= theta_q;
			endcase
		end
	end

	// track state and result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			started_q    <= 1'b0;
			last_x_q     <= '0;
			last_y_q     <= '0;
			last_stamp_q <= '0;
			vel_x_q      <= '0;
			vel_y_q      <= '0;
			res_valid_q  <= 1'b0;
		end else begin
			if (cmd.op == OP_SEED) begin
				started_q <= 1'b1;
				last_x_q  <= px_q;
				last_y_q  <= py_q;
				vel_x_q   <= '0;
				vel_y_q   <= '0;
			end
			if (mul_done && cmd.op == OP_GX)
				last_x_q <= sat32_f(addmag36(pred_x_q, {2'b00, prod[63:32]}, r_x_q[32]));
			if (mul_done && cmd.op == OP_GY)
				last_y_q <= sat32_f(addmag36(pred_y_q, {2'b00, prod[63:32]}, r_y_q[32]));
			if (div_done && cmd.op == OP_DVX)
				vel_x_q <= sat48_f(vneg_q ? 50'(vel_x_q) - signed'({2'b00, quot})
					: 50'(vel_x_q) + signed'({2'b00, quot}));
			if (div_done && cmd.op == OP_DVY)
				vel_y_q <= sat48_f(vneg_q ? 50'(vel_y_q) - signed'({2'b00, quot})
					: 50'(vel_y_q) + signed'({2'b00, quot}));
			// load the result, or drop it once taken
			if (cmd.op == OP_EMIT && out_free) begin
				res_valid_q <= 1'b1;
				if (!req_q) last_stamp_q <= stamp_q;
			end else if (res_valid_q && !res_stall) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	// item working registers
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			req_q     <= meas_data.req_type;
			stamp_q   <= meas_data.stamp;
			px_q      <= meas_data.pos_x;
			py_q      <= meas_data.pos_y;
			dt_q      <= signed'({1'b0, meas_data.stamp} - {1'b0, last_stamp_q});
			matched_q <= meas_data.req_type && !started_q;
			gap_q     <= '0;
		end
		if (mul_done) begin
			case (cmd.op)
				OP_GV:  gv_q <= prod[32:0];
				OP_GP:  gp_q <= 33'h100000000 - prod[32:0];
				OP_PX:  pred_x_q <= pred_f(last_x_q, prod[79:16], vel_x_q[47] ^ dt_q[32]);
				OP_PY:  pred_y_q <= pred_f(last_y_q, prod[79:16], vel_y_q[47] ^ dt_q[32]);
				OP_VX: begin
					vm_q   <= prod[63:16];
					vneg_q <= r_x_q[32];
				end
				OP_VY: begin
					vm_q   <= prod[63:16];
					vneg_q <= r_y_q[32];
				end
				OP_SQX: sq_x_q <= prod[64:0];
				OP_SQY: sum_q  <= {1'b0, sq_x_q} + {1'b0, prod[64:0]};
				default: vneg_q <= vneg_q;
			endcase
		end
		if (cmd.op == OP_RES) begin
			r_x_q <= 33'(px_q) - 33'(pred_x_q);
			r_y_q <= 33'(py_q) - 33'(pred_y_q);
		end
		if (root_done && cmd.op == OP_ROOT && root <= gate_dist_q) begin
			gap_q     <= root;
			matched_q <= 1'b1;
		end
		if (cmd.op == OP_EMIT && out_free) begin
			res_q.filt_x  <= req_q ? 32'sd0 : last_x_q;
			res_q.filt_y  <= req_q ? 32'sd0 : last_y_q;
			res_q.gap     <= gap_q;
			res_q.matched <= !req_q || matched_q;
		end
	end

	assign res_valid = res_valid_q;
	assign res_data  = res_q;

endmodule

`default_nettype wire

// File: sv/alpha_beta_tracker_2d_unit.sv
// Channel   Direction  Handshake               Payload
// meas      in         meas_valid/meas_stall   meas_data (req_type, stamp, pos_x, pos_y)
// res       out        res_valid/res_stall     res_data (filt_x, filt_y, gap, matched)
// cfg       in         cfg_valid/cfg_ready     cfg_index, cfg_data
//
// One item at a time; a 16-bit-digit multiplier, a 48-step divider and a 32-step
// square root are shared by the arithmetic steps.
// Measurement with velocity update runs the two divisions; query runs the square
// root; seed or gated query runs no iterative unit.
// Reset clears the track and loads the default registers; no clearing pass.
// A result waits in the output register under res_stall while the next item is taken.
`default_nettype none

module alpha_beta_tracker_2d_unit (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             meas_valid,
	output logic                             meas_stall,
	input  abt2d_pkg::meas_item_t            meas_data,
	output logic                             res_valid,
	input  logic                             res_stall,
	output abt2d_pkg::res_item_t             res_data,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [abt2d_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [31:0]                      cfg_data
);
	import abt2d_pkg::*;

	cmd_t cmd;
	sts_t sts;

	abt2d_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.meas_valid (meas_valid),
		.meas_stall (meas_stall),
		.cmd        (cmd),
		.sts        (sts)
	);

	abt2d_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.meas_data (meas_data),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res_data  (res_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

endmodule

`default_nettype wire
